// ===== design/force_fingerprint_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator: assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FORCE_FINGERPRINT_ACCUMULATOR_ASSERT_SVH
`define FORCE_FINGERPRINT_ACCUMULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FFA_ASSERT_IMP(lbl, ante, cons, msg)

`define FFA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator package
// Shared constants, command types and helper functions.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Word width of ids, acceleration patterns and fingerprint words.
  localparam int unsigned WORD_W = 64;

  // Number of fingerprint word slots on the result.
  localparam int unsigned FP_WORDS = 4;

  // Default number of active lanes.
  localparam int unsigned LANE_COUNT_DEFAULT = 4;

  // Hash rounds per lane: the id, then x, y and z.
  localparam int unsigned NUM_ROUNDS = 4;
  localparam int unsigned ROUND_W = $clog2(NUM_ROUNDS);

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // Finalizer constants.
  localparam logic [WORD_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WORD_W-1:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;

  // Per-lane seeds.
  localparam logic [WORD_W-1:0] LANE_SEED [FP_WORDS] = '{
    64'h243f_6a88_85a3_08d3,
    64'h1319_8a2e_0370_7344,
    64'ha409_3822_299f_31d0,
    64'h082e_fa98_ec4e_6c89
  };

  // Operation carried in the item's tuser bit.
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  // One queued command.
  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] pid;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } cmd_t;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic               add_en;
    logic               mul_a_en;
    logic               mul_b_en;
    logic               use_shift27;
    logic               commit;
    logic               clear;
    logic [ROUND_W-1:0] round;
  } lane_ctl_t;

  // Rotate left by a constant, nonzero amount below the word width.
  function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] v, int unsigned amt);
    rotl64 = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

// ===== design/ffa_queue.sv =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator: front end
// Accepts items, classifies them into commands and queues them for the engine.
// ----------------------------------------------------------------------------
module ffa_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  input  logic [4*ffa_pkg::WORD_W-1:0]     s_tdata_i,
  input  logic                             s_tuser_i,
  output logic                             q_valid_o,
  output ffa_pkg::cmd_t                    q_cmd_o,
  input  logic                             q_pop_i
);

  ffa_pkg::cmd_t                  mem_q [ffa_pkg::QUEUE_DEPTH];
  logic [ffa_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ffa_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ffa_pkg::QPTR_W:0]       cnt_q, cnt_d;
  logic                           push;
  ffa_pkg::cmd_t                  cmd_in;

  // Classify the incoming item.
  always_comb begin
    cmd_in.op  = s_tuser_i ? ffa_pkg::OP_CLEAR : ffa_pkg::OP_ACCUM;
    cmd_in.pid = s_tdata_i[0*ffa_pkg::WORD_W +: ffa_pkg::WORD_W];
    cmd_in.x   = s_tdata_i[1*ffa_pkg::WORD_W +: ffa_pkg::WORD_W];
    cmd_in.y   = s_tdata_i[2*ffa_pkg::WORD_W +: ffa_pkg::WORD_W];
    cmd_in.z   = s_tdata_i[3*ffa_pkg::WORD_W +: ffa_pkg::WORD_W];
  end

  assign s_tready_o = (cnt_q != (ffa_pkg::QPTR_W+1)'(ffa_pkg::QUEUE_DEPTH));
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== design/ffa_lane.sv =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator: hash lane
// One lane of the finalizer datapath with its sum and xor words.
// ----------------------------------------------------------------------------
module ffa_lane #(
  parameter int unsigned LaneIdx = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffa_pkg::lane_ctl_t           ctl_i,
  input  ffa_pkg::cmd_t                cmd_i,
  output logic [ffa_pkg::WORD_W-1:0]   sum_nx_o,
  output logic [ffa_pkg::WORD_W-1:0]   xor_nx_o
);

  localparam int unsigned RotX = 7 + 5 * LaneIdx;
  localparam int unsigned RotY = 13 + 7 * LaneIdx;
  localparam int unsigned RotZ = 19 + 9 * LaneIdx;

  logic [ffa_pkg::WORD_W-1:0] v_q;
  logic [ffa_pkg::WORD_W-1:0] pp0_q, pp0_d;
  logic [31:0]                ppx_q, ppx_d;
  logic [ffa_pkg::WORD_W-1:0] sum_q, xor_q;
  logic [ffa_pkg::WORD_W-1:0] h_out, mix_in, mul_src, mul_c;

  // Finishing xorshift of the previous finalizer round.
  assign h_out = v_q ^ (v_q >> 31);

  // Value entering the next finalizer round.
  always_comb begin
    unique case (ctl_i.round)
      2'd0:    mix_in = cmd_i.pid ^ ffa_pkg::LANE_SEED[LaneIdx];
      2'd1:    mix_in = h_out ^ ffa_pkg::rotl64(cmd_i.x, RotX);
      2'd2:    mix_in = h_out ^ ffa_pkg::rotl64(cmd_i.y, RotY);
      default: mix_in = h_out ^ ffa_pkg::rotl64(cmd_i.z, RotZ);
    endcase
  end

  // Xorshift and constant for the multiply step, split into partial products.
  always_comb begin
    mul_src = ctl_i.use_shift27 ? (v_q ^ (v_q >> 27)) : (v_q ^ (v_q >> 30));
    mul_c   = ctl_i.use_shift27 ? ffa_pkg::MIX_C2 : ffa_pkg::MIX_C1;
    pp0_d   = {32'd0, mul_src[31:0]} * {32'd0, mul_c[31:0]};
    ppx_d   = 32'(mul_src[63:32] * mul_c[31:0]) + 32'(mul_src[31:0] * mul_c[63:32]);
  end

  // Working value and partial product registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.add_en) begin
      v_q <= mix_in + ffa_pkg::GOLDEN;
    end else if (ctl_i.mul_b_en) begin
      v_q <= pp0_q + {ppx_q, 32'd0};
    end
    if (ctl_i.mul_a_en) begin
      pp0_q <= pp0_d;
      ppx_q <= ppx_d;
    end
  end

  // Next fingerprint words of this lane.
  assign sum_nx_o = ctl_i.clear ? '0 : sum_q + h_out;
  assign xor_nx_o = ctl_i.clear ? '0 : xor_q ^ h_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      xor_q <= '0;
    end else if (ctl_i.commit) begin
      sum_q <= sum_nx_o;
      xor_q <= xor_nx_o;
    end
  end

endmodule

// ===== design/ffa_engine.sv =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator: back end
// Sequences the finalizer rounds across all lanes and holds the result.
// ----------------------------------------------------------------------------
`include "force_fingerprint_accumulator_assert.svh"

module ffa_engine #(
  parameter int unsigned LaneCount = ffa_pkg::LANE_COUNT_DEFAULT
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           q_valid_i,
  input  ffa_pkg::cmd_t                                  q_cmd_i,
  output logic                                           q_pop_o,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output logic [ffa_pkg::FP_WORDS-1:0][ffa_pkg::WORD_W-1:0] out_sum_o,
  output logic [ffa_pkg::FP_WORDS-1:0][ffa_pkg::WORD_W-1:0] out_xor_o
);

  localparam logic [ffa_pkg::ROUND_W-1:0] RoundLast =
    ffa_pkg::ROUND_W'(ffa_pkg::NUM_ROUNDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_M1A,
    ST_M1B,
    ST_M2A,
    ST_M2B,
    ST_COMMIT
  } state_e;

  state_e                              state_q, state_d;
  logic [ffa_pkg::ROUND_W-1:0]         round_q, round_d;
  logic                                out_valid_q, out_valid_d;
  logic                                commit_go;
  ffa_pkg::lane_ctl_t                  ctl;
  logic [ffa_pkg::FP_WORDS-1:0][ffa_pkg::WORD_W-1:0] sum_nx, xor_nx;
  logic [ffa_pkg::FP_WORDS-1:0][ffa_pkg::WORD_W-1:0] out_sum_q, out_xor_q;

  // The result is written when the output register is free or being emptied.
  assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign q_pop_o   = commit_go;

  // Lane control decode.
  always_comb begin
    ctl.add_en      = (state_q == ST_ADD);
    ctl.mul_a_en    = (state_q == ST_M1A) || (state_q == ST_M2A);
    ctl.use_shift27 = (state_q == ST_M2A);
    ctl.mul_b_en    = (state_q == ST_M1B) || (state_q == ST_M2B);
    ctl.commit      = commit_go;
    ctl.clear       = (q_cmd_i.op == ffa_pkg::OP_CLEAR);
    ctl.round       = round_q;
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          round_d = '0;
          state_d = (q_cmd_i.op == ffa_pkg::OP_CLEAR) ? ST_COMMIT : ST_ADD;
        end
      end
      ST_ADD: state_d = ST_M1A;
      ST_M1A: state_d = ST_M1B;
      ST_M1B: state_d = ST_M2A;
      ST_M2A: state_d = ST_M2B;
      ST_M2B: begin
        if (round_q == RoundLast) begin
          state_d = ST_COMMIT;
        end else begin
          round_d = round_q + 1'b1;
          state_d = ST_ADD;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hash lanes; lanes past the configured count stay zero.
  for (genvar i = 0; i < ffa_pkg::FP_WORDS; i++) begin : g_lane
    if (i < LaneCount) begin : g_on
      ffa_lane #(
        .LaneIdx (i)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .cmd_i    (q_cmd_i),
        .sum_nx_o (sum_nx[i]),
        .xor_nx_o (xor_nx[i])
      );
    end else begin : g_off
      assign sum_nx[i] = '0;
      assign xor_nx[i] = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      out_sum_q <= sum_nx;
      out_xor_q <= xor_nx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_xor_o   = out_xor_q;

  // The queue head must stay in place while its command is being worked on.
  `FFA_ASSERT_IMP(a_head_held, state_q != ST_IDLE, q_valid_i, "queue head lost during work")
  // Four rounds run before the commit; earlier rounds loop back to the add step.
  `FFA_ASSERT_NXT(a_round_loop, state_q == ST_M2B && round_q != RoundLast,
                  state_q == ST_ADD, "round sequence broken")
  // A clear produces an all-zero result.
  `FFA_ASSERT_NXT(a_clear_zero, commit_go && q_cmd_i.op == ffa_pkg::OP_CLEAR,
                  out_sum_q == '0 && out_xor_q == '0 && out_valid_q,
                  "clear result not zero")

endmodule

// ===== design/force_fingerprint_accumulator.sv =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator
// Order-independent multi-lane fingerprint of particle id and acceleration.
//
//   Channel | Dir | Contents
//   s_axis  | in  | tuser: operation; tdata: id, accel x, y, z bits
//   m_axis  | out | tdata: sum words lanes 0..3, then xor words lanes 0..3
//
// An accumulate item goes from the queue head to the result register through
// one dispatch, four finalizer rounds, each an add and two split 64-bit
// multiplies in every lane, and one commit. A clear goes straight to commit.
// A two-entry command queue keeps taking items while the engine works, until full.
// Reset is asynchronous and zeroes all lane sum and xor words at once.
// A result waits in the output register until taken; the engine holds there.
// ----------------------------------------------------------------------------
module force_fingerprint_accumulator #(
  parameter int unsigned LaneCount = ffa_pkg::LANE_COUNT_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: particle_id, accel_x_bits, accel_y_bits, accel_z_bits.
  input  logic [4*ffa_pkg::WORD_W-1:0]     s_axis_tdata,
  // Fields from bit 0: operation.
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: sum_lane0..sum_lane3, xor_lane0..xor_lane3.
  output logic [8*ffa_pkg::WORD_W-1:0]     m_axis_tdata
);

  logic                                              q_valid;
  logic                                              q_pop;
  ffa_pkg::cmd_t                                     q_cmd;
  logic [ffa_pkg::FP_WORDS-1:0][ffa_pkg::WORD_W-1:0] out_sum, out_xor;

  // Front end: accept and queue.
  ffa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_pop_i    (q_pop)
  );

  // Back end: hash lanes and result register.
  ffa_engine #(
    .LaneCount (LaneCount)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sum_o   (out_sum),
    .out_xor_o   (out_xor)
  );

  // Sum words in the low half, xor words in the high half.
  assign m_axis_tdata = {out_xor, out_sum};

endmodule

// ===== verif/fingerprint_checker.sv =====
// ----------------------------------------------------------------------------
// Fingerprint checker
// Watches both stream channels of the force fingerprint accumulator, keeps
// its own copy of the lane sum and xor words, predicts the result word of
// every accepted item and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module fingerprint_checker #(
  parameter int unsigned LaneCount = ffa_pkg::LANE_COUNT_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  input  logic                         s_ready_i,
  // Fields from bit 0: particle_id, accel_x_bits, accel_y_bits, accel_z_bits.
  input  logic [4*ffa_pkg::WORD_W-1:0] s_data_i,
  // Fields from bit 0: operation.
  input  logic                         s_user_i,
  input  logic                         m_valid_i,
  input  logic                         m_ready_i,
  // Fields from bit 0: sum_lane0..sum_lane3, xor_lane0..xor_lane3.
  input  logic [8*ffa_pkg::WORD_W-1:0] m_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ffa_pkg::WORD_W-1:0]   word_t;
  typedef logic [8*ffa_pkg::WORD_W-1:0] result_t;

  // Predicted fingerprint store.
  word_t       lane_sum [ffa_pkg::FP_WORDS];
  word_t       lane_xor [ffa_pkg::FP_WORDS];
  // Result words still owed by the block, oldest first.
  result_t     expected_words_q [$];
  int unsigned mismatches;
  int unsigned results_seen;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_words_q.size();
  assign checked_o    = results_seen;

  // One splitmix64 finalizer round.
  function automatic word_t splitmix_final(input word_t v);
    word_t t;
    t = v + ffa_pkg::GOLDEN;
    t = (t ^ (t >> 30)) * ffa_pkg::MIX_C1;
    t = (t ^ (t >> 27)) * ffa_pkg::MIX_C2;
    return t ^ (t >> 31);
  endfunction

  function automatic word_t rot_left(input word_t v, input int unsigned amount);
    int unsigned r;
    r = amount & 63;
    if (r == 0) return v;
    return (v << r) | (v >> (ffa_pkg::WORD_W - r));
  endfunction

  // Hash one particle into every active lane.
  task automatic fold_particle(input word_t pid, input word_t ax, input word_t ay,
                               input word_t az);
    word_t h;
    for (int unsigned lane = 0; lane < LaneCount && lane < ffa_pkg::FP_WORDS; lane++) begin
      h = splitmix_final(pid ^ ffa_pkg::LANE_SEED[lane]);
      h = splitmix_final(h ^ rot_left(ax, 7 + 5 * lane));
      h = splitmix_final(h ^ rot_left(ay, 13 + 7 * lane));
      h = splitmix_final(h ^ rot_left(az, 19 + 9 * lane));
      lane_sum[lane] = lane_sum[lane] + h;
      lane_xor[lane] = lane_xor[lane] ^ h;
    end
  endtask

  task automatic wipe_store();
    for (int unsigned k = 0; k < ffa_pkg::FP_WORDS; k++) begin
      lane_sum[k] = '0;
      lane_xor[k] = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] fingerprint mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Compare finished results first, then predict for the item taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_word;
    word_t   got;
    word_t   want;
    string   field;
    if (!rst_ni) begin
      wipe_store();
      expected_words_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        results_seen++;
        if (expected_words_q.size() == 0) begin
          report_mismatch("result item with no item outstanding");
        end else begin
          exp_word = expected_words_q.pop_front();
          for (int unsigned k = 0; k < 2 * ffa_pkg::FP_WORDS; k++) begin
            got  = m_data_i[k*ffa_pkg::WORD_W +: ffa_pkg::WORD_W];
            want = exp_word[k*ffa_pkg::WORD_W +: ffa_pkg::WORD_W];
            if (got !== want) begin
              field = (k < ffa_pkg::FP_WORDS) ? $sformatf("sum_lane%0d", k)
                                              : $sformatf("xor_lane%0d", k - ffa_pkg::FP_WORDS);
              report_mismatch($sformatf("result %0d %s got %h expected %h",
                                        results_seen, field, got, want));
            end
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (ffa_pkg::op_e'(s_user_i) == ffa_pkg::OP_CLEAR) begin
          wipe_store();
        end else begin
          fold_particle(s_data_i[0 +: ffa_pkg::WORD_W],
                        s_data_i[ffa_pkg::WORD_W +: ffa_pkg::WORD_W],
                        s_data_i[2*ffa_pkg::WORD_W +: ffa_pkg::WORD_W],
                        s_data_i[3*ffa_pkg::WORD_W +: ffa_pkg::WORD_W]);
        end
        for (int unsigned k = 0; k < ffa_pkg::FP_WORDS; k++) begin
          exp_word[k*ffa_pkg::WORD_W +: ffa_pkg::WORD_W] = lane_sum[k];
          exp_word[(k+ffa_pkg::FP_WORDS)*ffa_pkg::WORD_W +: ffa_pkg::WORD_W] = lane_xor[k];
        end
        expected_words_q.push_back(exp_word);
      end
    end
  end

  // Anything still owed at the end of the run is a failure.
  task automatic flag_leftovers();
    if (expected_words_q.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived", expected_words_q.size()));
  endtask

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Force fingerprint accumulator testbench
// Drives directed and random particle and clear items into the accumulator
// with random gaps on both stream sides, lets the fingerprint checker predict
// and compare every result item, and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 40;

  typedef logic [ffa_pkg::WORD_W-1:0] word_t;

  // Binary64 patterns worth hitting often.
  localparam word_t PosInf   = 64'h7ff0_0000_0000_0000;
  localparam word_t NegInf   = 64'hfff0_0000_0000_0000;
  localparam word_t QuietNan = 64'h7ff8_0000_0000_0000;
  localparam word_t SigNan   = 64'h7ff0_0000_0000_0001;
  localparam word_t NegZero  = 64'h8000_0000_0000_0000;
  localparam word_t MinSub   = 64'h0000_0000_0000_0001;
  localparam word_t OnePos   = 64'h3ff0_0000_0000_0000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [4*ffa_pkg::WORD_W-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [8*ffa_pkg::WORD_W-1:0]  m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned idle_cycles = 0;
  int unsigned particles_sent = 0;
  int unsigned clears_sent = 0;
  bit          quiet_phase = 1'b0;

  always #4 clk_i = ~clk_i;

  force_fingerprint_accumulator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fingerprint_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Wait before an item; quiet phases run back to back.
  function automatic int unsigned draw_gap();
    if (quiet_phase) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly random bits, with extremes and float specials mixed in.
  function automatic word_t pick_pattern();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return PosInf;
      3:       return NegInf;
      4:       return QuietNan;
      5:       return NegZero;
      6:       return MinSub;
      7:       return OnePos ^ (rand_word() >> 12);
      default: return rand_word();
    endcase
  endfunction

  // Present one item from a falling edge and hold it until it is taken.
  task automatic send_item(input ffa_pkg::op_e op, input word_t pid, input word_t ax,
                           input word_t ay, input word_t az);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {az, ay, ax, pid};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == ffa_pkg::OP_CLEAR) clears_sent++;
    else particles_sent++;
    @(negedge clk_i);
  endtask

  // Result side: random stall before each result item.
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no item moved for %0d cycles", IdleLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    word_t pid;
    word_t ax;
    word_t ay;
    word_t az;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: clear with junk fields, extremes, float specials, seed hits.
    send_item(ffa_pkg::OP_CLEAR, '1, '1, '1, '1);
    send_item(ffa_pkg::OP_ACCUM, '0, '0, '0, '0);
    send_item(ffa_pkg::OP_ACCUM, '1, '1, '1, '1);
    send_item(ffa_pkg::OP_ACCUM, '0, PosInf, NegInf, QuietNan);
    send_item(ffa_pkg::OP_ACCUM, 64'd1, NegZero, NegZero, NegZero);
    send_item(ffa_pkg::OP_ACCUM, '1, MinSub, SigNan, OnePos);
    send_item(ffa_pkg::OP_ACCUM, '1, MinSub, SigNan, OnePos);
    send_item(ffa_pkg::OP_CLEAR, '0, '0, '0, '0);
    send_item(ffa_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(ffa_pkg::OP_ACCUM, ffa_pkg::LANE_SEED[0], '0, '0, '0);
    send_item(ffa_pkg::OP_ACCUM, ffa_pkg::LANE_SEED[3], '1, '0, '1);
    send_item(ffa_pkg::OP_ACCUM, (~ffa_pkg::GOLDEN + 64'd1) ^ ffa_pkg::LANE_SEED[1],
              OnePos, '1, '0);
    send_item(ffa_pkg::OP_ACCUM, {32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
    send_item(ffa_pkg::OP_ACCUM, {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
    quiet_phase = 1'b1;
    send_item(ffa_pkg::OP_ACCUM, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(ffa_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(ffa_pkg::OP_ACCUM, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(ffa_pkg::OP_ACCUM, rand_word(), rand_word(), rand_word(), rand_word());
    quiet_phase = 1'b0;

    // Random: mostly particles, occasional clears and repeats that cancel xor.
    pid = rand_word();
    ax  = rand_word();
    ay  = rand_word();
    az  = rand_word();
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 24) == 0) begin
        send_item(ffa_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(), rand_word());
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          pid = ($urandom_range(0, 7) == 0) ? pick_pattern() : rand_word();
          ax  = pick_pattern();
          ay  = pick_pattern();
          az  = pick_pattern();
        end
        send_item(ffa_pkg::OP_ACCUM, pid, ax, ay, az);
      end
    end
    s_axis_tvalid <= 1'b0;
    quiet_phase = 1'b0;

    // Drain, then give the engine a little extra time to show stray results.
    while (pending != 0) @(negedge clk_i);
    i_checker.flag_leftovers();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d particle items and %0d clears with random stalls on both sides;",
             particles_sent, clears_sent);
    $display("%0d result items compared word by word, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
